[design/lfht_pkg.sv]
// Shared constants, codes and controller/datapath handshake structs for the handle table.
`timescale 1ns / 1ps

package lfht_pkg;

    // Default number of slots
    localparam int LFHT_DEF_CAPACITY = 1024;

    // Occupied bits are kept in rows of this many slots
    localparam int LFHT_ROW_W = 64;

    // Field widths of the stream words
    localparam int LFHT_OP_W     = 2;
    localparam int LFHT_VALUE_W  = 64;
    localparam int LFHT_IDX_W    = 11;
    localparam int LFHT_RINDEX_W = 10;

    // Operation codes
    localparam logic [LFHT_OP_W-1:0] LFHT_OP_ADD    = 2'd0;
    localparam logic [LFHT_OP_W-1:0] LFHT_OP_FREE   = 2'd1;
    localparam logic [LFHT_OP_W-1:0] LFHT_OP_LOOKUP = 2'd2;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear_step;  // write one row of the occupied-bit memory with its reset pattern
        logic load;        // capture the input word
        logic read;        // read the target row and value
        logic decide;      // resolve the operation and update state
        logic scan;        // test one row of the full-row summary
        logic pick;        // take the lowest free bit of the fetched row
        logic emit;        // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_last;  // last row of the clearing pass
        logic need_scan;   // the filled row is full above the new slot
        logic scan_hit;    // the scanned row has a free slot
        logic out_ready;   // output register can take a result
    } t_sts;

endpackage

[design/lfht_ctrl.sv]
// Sequencing state machine of the handle table.
`timescale 1ns / 1ps

module lfht_ctrl
    import lfht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_READ   = 7'b0000100,
        S_DECIDE = 7'b0001000,
        S_SCAN   = 7'b0010000,
        S_PICK   = 7'b0100000,
        S_RESP   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Advance the state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_sts.need_scan ? S_SCAN : S_RESP;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_hit) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

[design/lfht_dpath.sv]
// Slot memories, lowest-free mark, free count and result registers of the handle table.
`timescale 1ns / 1ps

module lfht_dpath
    import lfht_pkg::*;
#(
    parameter int CAPACITY = LFHT_DEF_CAPACITY
)
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    input  logic [LFHT_OP_W-1:0]     i_op,
    input  logic [LFHT_VALUE_W-1:0]  i_value,
    input  logic [LFHT_IDX_W-1:0]    i_idx,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [1:0]               o_status,
    output logic [LFHT_RINDEX_W-1:0] o_rindex,
    output logic [LFHT_VALUE_W-1:0]  o_rvalue
);

    localparam int ROW_BITS = $clog2(LFHT_ROW_W);
    localparam int ROWS     = (CAPACITY + LFHT_ROW_W - 1) / LFHT_ROW_W;
    localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SPAN_W   = ROW_AW + ROW_BITS;
    localparam int MARK_W   = SPAN_W + 1;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Reset pattern of a row: slots past the capacity read as taken
    function automatic logic [LFHT_ROW_W-1:0] row_init(input logic [ROW_AW-1:0] row);
        logic [LFHT_ROW_W-1:0] bits;
        bits = '0;
        for (int b = 0; b < LFHT_ROW_W; b++) begin
            bits[b] = ((int'(row) * LFHT_ROW_W + b) >= CAPACITY);
        end
        return bits;
    endfunction

    // Position of the lowest set bit
    function automatic logic [ROW_BITS-1:0] first_set(input logic [LFHT_ROW_W-1:0] v);
        logic [ROW_BITS-1:0] pos;
        pos = '0;
        for (int b = LFHT_ROW_W - 1; b >= 0; b--) begin
            if (v[b]) begin
                pos = ROW_BITS'(b);
            end
        end
        return pos;
    endfunction

    // Input word
    logic [LFHT_OP_W-1:0]    r_op;
    logic [LFHT_VALUE_W-1:0] r_value;
    logic [LFHT_IDX_W-1:0]   r_idx;

    // Table state
    logic [MARK_W-1:0]       r_mark;
    logic [CNT_W-1:0]        r_count;
    logic [ROWS-1:0]         r_full_rows;
    logic [ROW_AW-1:0]       r_clr_row;
    logic [ROW_AW-1:0]       r_scan_row;

    // Memories
    logic [LFHT_ROW_W-1:0]   occ_mem [ROWS];
    logic [LFHT_VALUE_W-1:0] val_mem [CAPACITY];
    logic [LFHT_ROW_W-1:0]   r_occ_q;
    logic [LFHT_VALUE_W-1:0] r_val_q;

    // Result and output registers
    t_status                  r_res_status;
    logic [LFHT_RINDEX_W-1:0] r_res_index;
    logic [LFHT_VALUE_W-1:0]  r_res_value;
    logic                     r_out_valid;
    t_status                  r_out_status;
    logic [LFHT_RINDEX_W-1:0] r_out_index;
    logic [LFHT_VALUE_W-1:0]  r_out_value;

    // Decode
    logic                  idx_null;
    logic                  idx_range;
    logic [SPAN_W-1:0]     idx_slot;
    logic [SPAN_W-1:0]     tgt_slot;
    logic [ROW_AW-1:0]     tgt_row;
    logic [ROW_BITS-1:0]   tgt_bit;
    logic [LFHT_ROW_W-1:0] bit_mask;
    logic [LFHT_ROW_W-1:0] set_row;
    logic [LFHT_ROW_W-1:0] clr_row;
    logic [LFHT_ROW_W-1:0] above_free;
    logic                  occupied;
    logic                  tbl_full;
    logic                  last_free;
    logic                  is_add;
    logic                  is_ref;
    logic                  add_ok;
    logic                  free_ok;
    logic [ROW_AW-1:0]     rd_row;
    logic                  occ_we;
    logic [ROW_AW-1:0]     occ_waddr;
    logic [LFHT_ROW_W-1:0] occ_wdata;
    t_status               n_res_status;
    logic [LFHT_RINDEX_W-1:0] n_res_index;
    logic [LFHT_VALUE_W-1:0]  n_res_value;

    // Resolve the target slot and the operation outcome
    always_comb begin
        idx_null   = (r_idx == '1);
        idx_range  = !idx_null && (r_idx[LFHT_IDX_W-1] ||
                     (32'(r_idx[LFHT_IDX_W-2:0]) >= CAPACITY));
        idx_slot   = SPAN_W'(r_idx[LFHT_IDX_W-2:0]);
        is_add     = (r_op == LFHT_OP_ADD);
        is_ref     = (r_op == LFHT_OP_FREE) || (r_op == LFHT_OP_LOOKUP);
        tgt_slot   = is_add ? r_mark[SPAN_W-1:0] : idx_slot;
        tgt_row    = tgt_slot[SPAN_W-1:ROW_BITS];
        tgt_bit    = tgt_slot[ROW_BITS-1:0];
        bit_mask   = LFHT_ROW_W'(1) << tgt_bit;
        set_row    = r_occ_q | bit_mask;
        clr_row    = r_occ_q & ~bit_mask;
        above_free = ~set_row & ({LFHT_ROW_W{1'b1}} << tgt_bit);
        occupied   = |(r_occ_q & bit_mask);
        tbl_full   = (r_count == '0);
        last_free  = (r_count == CNT_W'(1));
        add_ok     = is_add && !tbl_full;
        free_ok    = (r_op == LFHT_OP_FREE) && !idx_null && !idx_range && occupied;

        n_res_status = ST_OK;
        n_res_index  = '0;
        n_res_value  = '0;
        if (is_add) begin
            if (tbl_full) begin
                n_res_status = ST_FULL;
            end else begin
                n_res_index = LFHT_RINDEX_W'(tgt_slot);
            end
        end else if (is_ref && !idx_null) begin
            if (idx_range) begin
                n_res_status = ST_RANGE;
            end else if (!occupied) begin
                n_res_status = ST_EMPTY;
            end else if (r_op == LFHT_OP_LOOKUP) begin
                n_res_value = r_val_q;
            end
        end

        o_sts.clear_last = (r_clr_row == ROW_AW'(ROWS - 1));
        o_sts.need_scan  = add_ok && !last_free && (above_free == '0);
        o_sts.scan_hit   = !r_full_rows[r_scan_row];
        o_sts.out_ready  = !r_out_valid || i_out_ready;

        rd_row    = i_cmd.scan ? r_scan_row : tgt_row;
        occ_we    = i_cmd.clear_step || (i_cmd.decide && (add_ok || free_ok));
        occ_waddr = i_cmd.clear_step ? r_clr_row : tgt_row;
        occ_wdata = i_cmd.clear_step ? row_init(r_clr_row) : (add_ok ? set_row : clr_row);
    end

    // Occupied-bit memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (occ_we) begin
            occ_mem[occ_waddr] <= occ_wdata;
        end
        r_occ_q <= occ_mem[rd_row];
    end

    // Value memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide && add_ok) begin
            val_mem[tgt_slot[SLOT_W-1:0]] <= r_value;
        end
        if (i_cmd.read) begin
            r_val_q <= val_mem[tgt_slot[SLOT_W-1:0]];
        end
    end

    // Capture the input word, register the resolved result and walk the row summary
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_value <= i_value;
            r_idx   <= i_idx;
        end
        if (i_cmd.decide) begin
            r_scan_row   <= tgt_row + ROW_AW'(1);
            r_res_status <= n_res_status;
            r_res_index  <= n_res_index;
            r_res_value  <= n_res_value;
        end else if (i_cmd.scan && !o_sts.scan_hit) begin
            r_scan_row <= r_scan_row + ROW_AW'(1);
        end
    end

    // Update the mark, the count, the summary and the clearing pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark      <= '0;
            r_count     <= CNT_W'(CAPACITY);
            r_full_rows <= '0;
            r_clr_row   <= '0;
        end else begin
            if (i_cmd.clear_step && !o_sts.clear_last) begin
                r_clr_row <= r_clr_row + ROW_AW'(1);
            end
            if (i_cmd.decide && add_ok) begin
                r_count              <= r_count - CNT_W'(1);
                r_full_rows[tgt_row] <= (set_row == '1);
                if (last_free) begin
                    r_mark <= MARK_W'(CAPACITY);
                end else if (above_free != '0) begin
                    r_mark <= MARK_W'({tgt_row, first_set(above_free)});
                end
            end
            if (i_cmd.decide && free_ok) begin
                r_count              <= r_count + CNT_W'(1);
                r_full_rows[tgt_row] <= 1'b0;
                if (MARK_W'(tgt_slot) < r_mark) begin
                    r_mark <= MARK_W'(tgt_slot);
                end
            end
            if (i_cmd.pick) begin
                r_mark <= MARK_W'({r_scan_row, first_set(~r_occ_q)});
            end
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= r_res_status;
            r_out_index  <= r_res_index;
            r_out_value  <= r_res_value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_rindex    = r_out_index;
    assign o_rvalue    = r_out_value;

endmodule

[design/lowest_free_handle_table.sv]
// Top level of the lowest-free-slot handle table.
`timescale 1ns / 1ps
//
// Use: each word on the input stream is one request. tuser carries the operation
// (add, free, look up); tdata carries the value to store and the signed slot index.
// Every request gives exactly one word on the output stream: tuser carries the
// status (ok, full, out of range, empty), tdata the assigned handle and the value read.
// An add takes the lowest free slot; a free returns its slot; index -1 does nothing.
// From acceptance a request passes through the accept, memory read, resolve and
// respond states. A new request is taken in the cycle after the result is handed
// to the output register. An add that fills the rest of its 64-slot row also passes
// through the scan and pick states, the scan walking the row summary past full rows
// to the next free slot. After reset the occupied-bit memory is cleared one row per
// cycle, CAPACITY/64 rows rounded up; no request is taken until then.
// The output register holds its word while the receiver stalls; a finished result
// waits there and the next request still starts, stalling only at its own result.
//
module lowest_free_handle_table
    import lfht_pkg::*;
#(
    parameter int CAPACITY = LFHT_DEF_CAPACITY
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [79:0] i_s_tdata,   // [63:0] value, [74:64] slot_index, [79:75] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] operation
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata,   // [9:0] result_index, [73:10] result_value, [79:74] zero
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    t_cmd                     cmd;
    t_sts                     sts;
    logic [1:0]               out_status;
    logic [LFHT_RINDEX_W-1:0] out_index;
    logic [LFHT_VALUE_W-1:0]  out_value;

    lfht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lfht_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_op        (i_s_tuser),
        .i_value     (i_s_tdata[LFHT_VALUE_W-1:0]),
        .i_idx       (i_s_tdata[LFHT_VALUE_W+LFHT_IDX_W-1:LFHT_VALUE_W]),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_status    (out_status),
        .o_rindex    (out_index),
        .o_rvalue    (out_value)
    );

    // Pack the result word
    assign o_m_tuser = out_status;
    assign o_m_tdata = {6'd0, out_value, out_index};

endmodule

[tb/lowest_free_handle_table_test.sv]
// Self-checking stream testbench for the lowest-free-slot handle table.
`timescale 1ns / 1ps

module lowest_free_handle_table_test;
    import lfht_pkg::*;

    localparam int CAPACITY = LFHT_DEF_CAPACITY;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_REQUESTS = 600;
    localparam logic [LFHT_OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [LFHT_IDX_W-1:0] NULL_HANDLE = 11'h7FF;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ALT_BITS = 64'h5555_5555_5555_5555;

    // One request word plus an optional hand-written expectation
    typedef struct packed {
        logic [LFHT_OP_W-1:0]     op;
        logic [LFHT_VALUE_W-1:0]  value;
        logic [LFHT_IDX_W-1:0]    idx;
        logic                     fixed;
        t_status                  st;
        logic [LFHT_RINDEX_W-1:0] rindex;
        logic [LFHT_VALUE_W-1:0]  rvalue;
    } request_t;

    typedef struct packed {
        t_status                  st;
        logic [LFHT_RINDEX_W-1:0] rindex;
        logic [LFHT_VALUE_W-1:0]  rvalue;
    } reply_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;   // [63:0] value, [74:64] slot_index, [79:75] zero
    logic [1:0]  s_tuser = '0;   // [1:0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;        // [9:0] result_index, [73:10] result_value, [79:74] zero
    logic [1:0]  m_tuser;        // [1:0] status

    request_t cur_row = '0;
    bit       steady = 1'b0;
    int       stall_left = 0;
    int       cycle_count = 0;
    int       errors = 0;
    int       n_requests = 0;
    int       status_seen [4] = '{0, 0, 0, 0};

    // Shadow copy of the table
    logic [63:0] slot_value [CAPACITY];
    bit          slot_used  [CAPACITY];
    int          next_open = 0;
    int          free_count = CAPACITY;
    int          fill_top = 0;

    reply_t pending_replies [$];

    // Directed rows: reset state, value extremes, null handle, range and empty errors
    request_t directed_rows [25] = '{
        '{LFHT_OP_LOOKUP, 64'd0, 11'd0, 1'b1, ST_EMPTY, 10'd0, 64'd0},
        '{LFHT_OP_FREE, 64'd0, 11'd0, 1'b1, ST_EMPTY, 10'd0, 64'd0},
        '{LFHT_OP_ADD, ALL_ONES, 11'h7FF, 1'b1, ST_OK, 10'd0, 64'd0},
        '{LFHT_OP_ADD, 64'd0, 11'd0, 1'b1, ST_OK, 10'd1, 64'd0},
        '{LFHT_OP_ADD, 64'h8000_0000_0000_0001, 11'h3FF, 1'b1, ST_OK, 10'd2, 64'd0},
        '{LFHT_OP_LOOKUP, 64'd0, 11'd0, 1'b1, ST_OK, 10'd0, ALL_ONES},
        '{LFHT_OP_LOOKUP, ALL_ONES, 11'd1, 1'b1, ST_OK, 10'd0, 64'd0},
        '{LFHT_OP_LOOKUP, 64'd0, NULL_HANDLE, 1'b1, ST_OK, 10'd0, 64'd0},
        '{LFHT_OP_FREE, 64'd0, NULL_HANDLE, 1'b1, ST_OK, 10'd0, 64'd0},
        '{LFHT_OP_LOOKUP, 64'd0, 11'd1023, 1'b1, ST_EMPTY, 10'd0, 64'd0},
        '{LFHT_OP_FREE, 64'd0, 11'h7FE, 1'b1, ST_RANGE, 10'd0, 64'd0},
        '{LFHT_OP_LOOKUP, 64'd0, 11'h400, 1'b1, ST_RANGE, 10'd0, 64'd0},
        '{LFHT_OP_FREE, 64'd0, 11'h400, 1'b1, ST_RANGE, 10'd0, 64'd0},
        '{LFHT_OP_FREE, 64'd0, 11'd1, 1'b1, ST_OK, 10'd0, 64'd0},
        '{LFHT_OP_FREE, 64'd0, 11'd1, 1'b1, ST_EMPTY, 10'd0, 64'd0},
        '{LFHT_OP_ADD, ALT_BITS, 11'd0, 1'b1, ST_OK, 10'd1, 64'd0},
        '{OP_UNUSED, ALL_ONES, 11'h3FF, 1'b1, ST_OK, 10'd0, 64'd0},
        '{LFHT_OP_FREE, 64'd0, 11'd0, 1'b1, ST_OK, 10'd0, 64'd0},
        '{LFHT_OP_FREE, 64'd0, 11'd2, 1'b1, ST_OK, 10'd0, 64'd0},
        '{LFHT_OP_ADD, 64'h0123_4567_89AB_CDEF, 11'd0, 1'b0, ST_OK, 10'd0, 64'd0},
        '{LFHT_OP_ADD, 64'hFEDC_BA98_7654_3210, 11'd0, 1'b0, ST_OK, 10'd0, 64'd0},
        '{LFHT_OP_ADD, 64'd1, 11'd0, 1'b0, ST_OK, 10'd0, 64'd0},
        '{LFHT_OP_LOOKUP, 64'd0, 11'd2, 1'b0, ST_OK, 10'd0, 64'd0},
        '{LFHT_OP_LOOKUP, 64'd0, 11'd3, 1'b0, ST_OK, 10'd0, 64'd0},
        '{LFHT_OP_LOOKUP, 64'd0, 11'd1, 1'b1, ST_OK, 10'd0, ALT_BITS}
    };

    lowest_free_handle_table #(
        .CAPACITY(CAPACITY)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata(m_tdata),
        .o_m_tuser(m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Apply one request to the shadow table and return the reply it gives
    function automatic reply_t handle_table_result(logic [1:0] op, logic [63:0] value,
                                                   logic [10:0] idx);
        reply_t r;
        int     k;
        int     s;
        r.st = ST_OK;
        r.rindex = '0;
        r.rvalue = '0;
        k = int'($signed(idx));
        if (op == LFHT_OP_ADD) begin
            if (free_count == 0 || next_open >= CAPACITY) begin
                r.st = ST_FULL;
            end else begin
                s = next_open;
                slot_value[s] = value;
                slot_used[s] = 1'b1;
                free_count--;
                if (s > fill_top)
                    fill_top = s;
                // advance the mark to the next free slot above
                next_open = s + 1;
                while (next_open < CAPACITY && slot_used[next_open])
                    next_open++;
                r.rindex = 10'(s);
            end
        end else if (op == LFHT_OP_FREE || op == LFHT_OP_LOOKUP) begin
            if (idx == NULL_HANDLE) begin
                r.st = ST_OK;
            end else if (k < 0 || k >= CAPACITY) begin
                r.st = ST_RANGE;
            end else if (!slot_used[k]) begin
                r.st = ST_EMPTY;
            end else if (op == LFHT_OP_FREE) begin
                slot_used[k] = 1'b0;
                if (k < next_open)
                    next_open = k;
                free_count++;
            end else begin
                r.rvalue = slot_value[k];
            end
        end
        return r;
    endfunction

    // Idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 64'd0;
        if (r < 16)
            return ALL_ONES;
        return {$urandom, $urandom};
    endfunction

    // Handle for free or lookup: mostly within the used region, some null and bad ones
    function automatic logic [10:0] pick_handle();
        int r;
        int hi;
        r = $urandom_range(0, 99);
        hi = (fill_top + 2 < CAPACITY - 1) ? fill_top + 2 : CAPACITY - 1;
        if (r < 8)
            return NULL_HANDLE;
        if (r < 16)
            return 11'($urandom_range(1024, 2046));
        if (r < 28)
            return 11'($urandom_range(0, CAPACITY - 1));
        return 11'($urandom_range(0, hi));
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 40)
            $display("MISMATCH cycle %0d: %s", cycle_count, what);
    endtask

    // Present one word, after a random idle gap, and hold it until taken
    task automatic send_request(input request_t rq);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= rq.op;
        s_tdata <= {5'd0, rq.idx, rq.value};
        cur_row <= rq;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic send_plain(input logic [1:0] op, input logic [63:0] value,
                              input logic [10:0] idx);
        request_t rq;
        rq = '0;
        rq.op = op;
        rq.value = value;
        rq.idx = idx;
        send_request(rq);
    endtask

    // Drop valid and hold until every predicted word has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_replies.size() != 0)
            @(posedge i_clk);
    endtask

    // Predict each accepted word
    always @(posedge i_clk) begin
        reply_t pr;
        if (s_tvalid && s_tready) begin
            pr = handle_table_result(s_tuser, s_tdata[63:0], s_tdata[74:64]);
            if (cur_row.fixed) begin
                pr.st = cur_row.st;
                pr.rindex = cur_row.rindex;
                pr.rvalue = cur_row.rvalue;
            end
            pending_replies.push_back(pr);
            n_requests++;
        end
    end

    // Check result words and drive receiver stalls
    always @(posedge i_clk) begin
        reply_t want;
        if (m_tvalid && m_tready) begin
            status_seen[m_tuser]++;
            if (pending_replies.size() == 0) begin
                report_mismatch("result word with no request outstanding");
            end else begin
                want = pending_replies.pop_front();
                if (m_tuser != want.st)
                    report_mismatch($sformatf("status %0d, expected %0d", m_tuser, want.st));
                if (m_tdata[9:0] != want.rindex)
                    report_mismatch($sformatf("result_index %0d, expected %0d",
                                              m_tdata[9:0], want.rindex));
                if (m_tdata[73:10] != want.rvalue)
                    report_mismatch($sformatf("result_value %h, expected %h",
                                              m_tdata[73:10], want.rvalue));
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Hang guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_replies.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int n;
        int w_add;
        int w_free;
        int r;
        logic [1:0] op;

        for (int i = 0; i < CAPACITY; i++) begin
            slot_value[i] = '0;
            slot_used[i] = 1'b0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows
        for (int i = 0; i < 25; i++)
            send_request(directed_rows[i]);
        wait_drained();

        // Fill the table to the top, then overflow it
        n = free_count + 2;
        for (int i = 0; i < n; i++) begin
            steady = (i < 300);
            send_plain(LFHT_OP_ADD, pick_value(), 11'($urandom));
        end
        wait_drained();

        // Punch holes across rows, then refill so full rows must be scanned
        send_plain(LFHT_OP_FREE, 64'd0, 11'd1023);
        send_plain(LFHT_OP_FREE, 64'd0, 11'd64);
        send_plain(LFHT_OP_FREE, 64'd0, 11'd63);
        send_plain(LFHT_OP_FREE, 64'd0, 11'd0);
        for (int i = 0; i < 44; i++)
            send_plain(LFHT_OP_FREE, {$urandom, $urandom}, 11'($urandom_range(0, CAPACITY - 1)));
        for (int i = 0; i < 52; i++)
            send_plain(LFHT_OP_ADD, pick_value(), 11'($urandom));

        // Random mix, steered so the table neither stays full nor empty
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i % 64 == 0)
                steady = ($urandom_range(0, 3) == 0);
            w_add = (free_count < 8) ? 15 : 40;
            w_free = (free_count > CAPACITY - 8) ? 10 : 30;
            r = $urandom_range(0, w_add + w_free + 30 - 1);
            if (r < w_add)
                op = LFHT_OP_ADD;
            else if (r < w_add + w_free)
                op = LFHT_OP_FREE;
            else if (r < w_add + w_free + 25)
                op = LFHT_OP_LOOKUP;
            else
                op = OP_UNUSED;
            send_plain(op, pick_value(), (op == LFHT_OP_ADD) ? 11'($urandom) : pick_handle());
        end

        wait_drained();
        repeat (30) @(posedge i_clk);
        if (pending_replies.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived", pending_replies.size()));
        $display("Run covered %0d requests: %0d ok, %0d table full, %0d out of range, %0d empty",
                 n_requests, status_seen[ST_OK], status_seen[ST_FULL],
                 status_seen[ST_RANGE], status_seen[ST_EMPTY]);
        $display("Table filled to capacity and overflowed, then churned with random stalls");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
